@@ sv/scte_pkg.sv @@
// shared types, constants and helpers of the spike chain trigger
package scte_pkg;

    localparam int EVENT_DEPTH  = 1024;
    localparam int CHAIN_LENGTH = 5;
    localparam int FULL_RANGE   = 1000;
    localparam int QUEUE_DEPTH  = 2;

    localparam int TIME_W  = 48;
    localparam int CHAN_W  = 8;
    localparam int LIMIT_W = 24;
    localparam int RATE_W  = 10;
    localparam int IDX_W   = $clog2(EVENT_DEPTH);
    localparam int CNT_W   = $clog2(EVENT_DEPTH + 1);
    localparam int POS_W   = 3;
    localparam int CHAINS_W = CHAN_W * CHAIN_LENGTH;
    localparam int CFG_W   = 40;
    localparam int CADDR_W = 3;
    localparam int EVENT_W = TIME_W + CHAN_W;

    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_CHAIN  = 2'd1;
    localparam logic [1:0] REQ_RATE   = 2'd2;

    localparam logic [CADDR_W-1:0] CFG_MAX_GAP      = 3'd0;
    localparam logic [CADDR_W-1:0] CFG_TRIG_DUR     = 3'd1;
    localparam logic [CADDR_W-1:0] CFG_REFRACTORY   = 3'd2;
    localparam logic [CADDR_W-1:0] CFG_RECENT       = 3'd3;
    localparam logic [CADDR_W-1:0] CFG_RATE_WIN     = 3'd4;
    localparam logic [CADDR_W-1:0] CFG_CHAINS       = 3'd5;

    typedef enum logic [1:0] {
        OP_RECORD,
        OP_CHAIN,
        OP_RATE,
        OP_NONE
    } op_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TIME_W-1:0] timestamp;
        logic [CHAN_W-1:0] channel;
    } item_t;

    typedef struct packed {
        logic              trigger_line;
        logic              chain_found;
        logic [RATE_W-1:0] rate_count;
    } result_t;

    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] timestamp;
        logic [CHAN_W-1:0] channel;
    } op_item_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]  max_gap;
        logic [LIMIT_W-1:0]  trigger_duration;
        logic [LIMIT_W-1:0]  refractory_period;
        logic [LIMIT_W-1:0]  recent_window;
        logic [LIMIT_W-1:0]  rate_window;
        logic [CHAINS_W-1:0] chain_channels;
    } cfg_t;

    // signed gap later - earlier exceeds limit
    function automatic logic gap_over(input logic [TIME_W-1:0] later,
                                      input logic [TIME_W-1:0] earlier,
                                      input logic [LIMIT_W-1:0] limit);
        logic signed [TIME_W:0] diff;
        diff = $signed({1'b0, later}) - $signed({1'b0, earlier});
        return diff > $signed({{(TIME_W + 1 - LIMIT_W){1'b0}}, limit});
    endfunction

    function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(EVENT_DEPTH - 1) : idx - 1'b1;
    endfunction

endpackage

@@ sv/scte_ram.sv @@
// generic single write port ram with registered read
module scte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/scte_front.sv @@
// front end: accepts items, classifies them and queues them for the back end
module scte_front
    import scte_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  item_t    item,
    output logic     q_empty,
    input  logic     q_pop,
    output op_item_t q_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    op_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    op_t               op_class;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        unique case (item.req_type)
            REQ_RECORD: op_class = OP_RECORD;
            REQ_CHAIN:  op_class = OP_CHAIN;
            REQ_RATE:   op_class = OP_RATE;
            default:    op_class = OP_NONE;
        endcase
    end

    assign full    = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && !q_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= '{op: op_class, timestamp: item.timestamp,
                                       channel: item.channel};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ sv/scte_back.sv @@
// back end: event ring, chain and rate walks, result register
module scte_back
    import scte_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     q_empty,
    output logic     q_pop,
    input  op_item_t q_item,
    output logic     empty,
    input  logic     pop,
    output result_t  result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_FETCH,
        S_EVAL
    } state_t;

    state_t              state_reg, state_next;
    op_item_t            item_reg, item_next;
    logic                mid_reg, mid_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [TIME_W-1:0]   ref_time_reg, ref_time_next;
    logic [RATE_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]    wi_reg, wi_next;
    logic [CNT_W-1:0]    stored_reg, stored_next;
    logic                lce_valid_reg, lce_valid_next;
    logic [IDX_W-1:0]    lce_reg, lce_next;
    logic                trig_reg, trig_next;
    logic [TIME_W-1:0]   tstart_reg, tstart_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                ram_we;
    logic [EVENT_W-1:0]  ram_rdata;
    logic [TIME_W-1:0]   ev_time;
    logic [CHAN_W-1:0]   ev_chan;
    logic [CHAN_W-1:0]   want_chan;

    scte_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (EVENT_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wi_reg),
        .wdata ({item_reg.timestamp, item_reg.channel}),
        .raddr (cur_reg),
        .rdata (ram_rdata)
    );

    assign ev_time   = ram_rdata[EVENT_W-1:CHAN_W];
    assign ev_chan   = ram_rdata[CHAN_W-1:0];
    assign want_chan = cfg.chain_channels[CHAN_W*pos_reg +: CHAN_W];
    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty && !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        mid_next       = mid_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        ref_time_next  = ref_time_reg;
        count_next     = count_reg;
        wi_next        = wi_reg;
        stored_next    = stored_reg;
        lce_valid_next = lce_valid_reg;
        lce_next       = lce_reg;
        trig_next      = trig_reg;
        tstart_next    = tstart_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        ram_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    item_next  = q_item;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                out_next   = '{trigger_line: trig_reg, chain_found: 1'b0, rate_count: '0};
                cur_next   = step_back(wi_reg);
                left_next  = stored_reg;
                count_next = '0;
                mid_next   = 1'b0;
                pos_next   = POS_W'(CHAIN_LENGTH - 1);
                state_next = S_IDLE;
                unique case (item_reg.op)
                    OP_RECORD:
                    begin
                        ram_we = 1'b1;
                        if (lce_valid_reg && lce_reg == wi_reg)
                        begin
                            lce_valid_next = 1'b0;
                        end
                        wi_next = (wi_reg == IDX_W'(EVENT_DEPTH - 1)) ? '0 : wi_reg + 1'b1;
                        if (stored_reg != CNT_W'(EVENT_DEPTH))
                        begin
                            stored_next = stored_reg + 1'b1;
                        end
                        out_valid_next = 1'b1;
                    end
                    OP_CHAIN:
                    begin
                        if (stored_reg == '0)
                        begin
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            if (trig_reg && gap_over(item_reg.timestamp, tstart_reg,
                                                     cfg.trigger_duration))
                            begin
                                trig_next = 1'b0;
                            end
                            state_next = S_FETCH;
                        end
                    end
                    OP_RATE:
                    begin
                        if (stored_reg == '0)
                        begin
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            ref_time_next = (item_reg.timestamp < TIME_W'(cfg.rate_window))
                                            ? '0
                                            : item_reg.timestamp - TIME_W'(cfg.rate_window);
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        out_valid_next = 1'b1;
                    end
                endcase
            end
            S_FETCH:
            begin
                if (left_reg == '0)
                begin
                    out_next       = '{trigger_line: trig_reg, chain_found: 1'b0,
                                       rate_count: count_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                out_next   = '{trigger_line: trig_reg, chain_found: 1'b0,
                               rate_count: count_reg};
                state_next = S_FETCH;
                if (item_reg.op == OP_RATE)
                begin
                    if (ev_time > ref_time_reg)
                    begin
                        count_next = count_reg + 1'b1;
                        cur_next   = step_back(cur_reg);
                        left_next  = left_reg - 1'b1;
                        if (count_reg + 1'b1 == RATE_W'(FULL_RANGE))
                        begin
                            out_next.rate_count = count_reg + 1'b1;
                            out_valid_next      = 1'b1;
                            state_next          = S_IDLE;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (!mid_reg)
                begin
                    // looking for the chain end spike
                    if (gap_over(item_reg.timestamp, ev_time, cfg.recent_window))
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else if (ev_chan != want_chan)
                    begin
                        cur_next  = step_back(cur_reg);
                        left_next = left_reg - 1'b1;
                    end
                    else if (lce_valid_reg && lce_reg == cur_reg)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        lce_valid_next = 1'b1;
                        lce_next       = cur_reg;
                        ref_time_next  = ev_time;
                        mid_next       = 1'b1;
                        pos_next       = POS_W'(CHAIN_LENGTH - 2);
                    end
                end
                else
                begin
                    if (gap_over(ref_time_reg, ev_time, cfg.max_gap))
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else if (ev_chan != want_chan)
                    begin
                        cur_next  = step_back(cur_reg);
                        left_next = left_reg - 1'b1;
                    end
                    else if (pos_reg != '0)
                    begin
                        ref_time_next = ev_time;
                        pos_next      = pos_reg - 1'b1;
                    end
                    else
                    begin
                        // complete chain
                        if (!trig_reg && gap_over(item_reg.timestamp, tstart_reg,
                                                  cfg.refractory_period))
                        begin
                            trig_next   = 1'b1;
                            tstart_next = item_reg.timestamp;
                        end
                        out_next       = '{trigger_line: trig_next, chain_found: 1'b1,
                                           rate_count: '0};
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '{op: OP_NONE, timestamp: '0, channel: '0};
            mid_reg       <= 1'b0;
            pos_reg       <= '0;
            cur_reg       <= '0;
            left_reg      <= '0;
            ref_time_reg  <= '0;
            count_reg     <= '0;
            wi_reg        <= '0;
            stored_reg    <= '0;
            lce_valid_reg <= 1'b0;
            lce_reg       <= '0;
            trig_reg      <= 1'b0;
            tstart_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            mid_reg       <= mid_next;
            pos_reg       <= pos_next;
            cur_reg       <= cur_next;
            left_reg      <= left_next;
            ref_time_reg  <= ref_time_next;
            count_reg     <= count_next;
            wi_reg        <= wi_next;
            stored_reg    <= stored_next;
            lce_valid_reg <= lce_valid_next;
            lce_reg       <= lce_next;
            trig_reg      <= trig_next;
            tstart_reg    <= tstart_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

@@ sv/spike_chain_trigger_top.sv @@
// top level of the spike chain trigger: configuration registers, front and back end
// A record passes through S_IDLE and S_START in the back end, which write it to the ring ram
// and load the output register. A poll walks the ring from the newest event back: each
// step reads one event from the ring ram in S_FETCH and evaluates it in S_EVAL; a chain match
// reads the same entry again for the next electrode, and a walk that runs out of stored
// events ends in S_FETCH. A rate poll stops once the count saturates. A two entry
// input queue and an output register let items be pushed while a result waits to be popped.
module spike_chain_trigger_top
    import scte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  item_t              item,
    output logic               empty,
    input  logic               pop,
    output result_t            result,
    input  logic               cfg_en,
    input  logic [CADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]   cfg_data
);

    cfg_t     cfg_reg;
    logic     q_empty;
    logic     q_pop;
    op_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{max_gap: LIMIT_W'(100), trigger_duration: LIMIT_W'(50),
                         refractory_period: LIMIT_W'(10000), recent_window: LIMIT_W'(1000),
                         rate_window: LIMIT_W'(600000), chain_channels: '0};
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                CFG_MAX_GAP:      cfg_reg.max_gap           <= cfg_data[LIMIT_W-1:0];
                CFG_TRIG_DUR:     cfg_reg.trigger_duration  <= cfg_data[LIMIT_W-1:0];
                CFG_REFRACTORY:   cfg_reg.refractory_period <= cfg_data[LIMIT_W-1:0];
                CFG_RECENT:       cfg_reg.recent_window     <= cfg_data[LIMIT_W-1:0];
                CFG_RATE_WIN:     cfg_reg.rate_window       <= cfg_data[LIMIT_W-1:0];
                CFG_CHAINS:       cfg_reg.chain_channels    <= cfg_data[CHAINS_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    scte_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    scte_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

`ifndef NO_ASSERTIONS
    a_found_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.chain_found && result.rate_count != '0))
        else $error("chain result carries a rate count");

    a_rate_sat: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.rate_count <= RATE_W'(FULL_RANGE))
        else $error("rate count above full range");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty && empty)
        else $error("back end took an item while busy or queue empty");
`endif

endmodule
